FILE: sv/mwe_pkg.sv
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared constants, types and helpers of the Microwire EEPROM slave.
// ----------------------------------------------------------------------------
package mwe_pkg;

    localparam int ADDR_BITS   = 6;
    localparam int WORD_COUNT  = 64;
    localparam int WORD_BITS   = 16;
    localparam int OPC_BITS    = 3;
    localparam int OPADDR_BITS = OPC_BITS + ADDR_BITS;
    localparam int BL_MAX      = (OPADDR_BITS > WORD_BITS) ? OPADDR_BITS : WORD_BITS;
    localparam int BL_BITS     = $clog2(BL_MAX + 1);
    localparam int RAM_AW      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    typedef logic [OPC_BITS-1:0]  t_opcode;
    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [RAM_AW-1:0]    t_ram_addr;
    typedef logic [BL_BITS-1:0]   t_bits_left;

    localparam t_opcode OP_READ  = OPC_BITS'(6);
    localparam t_opcode OP_WRITE = OPC_BITS'(5);
    localparam t_opcode OP_ERASE = OPC_BITS'(7);
    localparam t_opcode OP_EWEN  = OPC_BITS'(4);

    typedef enum logic [2:0] {
        PH_OPADDR  = 3'b001,
        PH_DATAIN  = 3'b010,
        PH_DATAOUT = 3'b100
    } t_phase;

    typedef struct packed {
        logic  cmd;
        logic  clock_level;
        logic  select_level;
        logic  data_in_level;
        logic  request_level;
        t_addr load_addr;
        t_word load_data;
    } t_item;

    typedef struct packed {
        logic data_out;
        logic grant;
        logic clock_echo;
        logic select_echo;
        logic data_in_echo;
        logic request_echo;
    } t_result;

    function automatic logic addr_in_range(input t_addr addr);
        return (int'(addr) < WORD_COUNT);
    endfunction

    function automatic t_ram_addr ram_index(input t_addr addr);
        logic [ADDR_BITS+RAM_AW-1:0] ext;
        ext = {{RAM_AW{1'b0}}, addr};
        return ext[RAM_AW-1:0];
    endfunction

endpackage

FILE: sv/mwe_ram.sv
// ----------------------------------------------------------------------------
// mwe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/mwe_serial.sv
// ----------------------------------------------------------------------------
// mwe_serial
// Control register latch and Microwire bit engine with its word store.
// ----------------------------------------------------------------------------
module mwe_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  mwe_pkg::t_item  i_item,
    output mwe_pkg::t_result o_result
);

    logic                 r_clk, r_sel, r_din, r_req, r_out;
    mwe_pkg::t_phase      r_phase;
    mwe_pkg::t_bits_left  r_bits_left;
    logic [mwe_pkg::OPADDR_BITS-1:0] r_opaddr;
    mwe_pkg::t_word       r_shift;
    logic                 r_load_pend;
    logic                 r_rd_ok;
    logic [mwe_pkg::WORD_COUNT-1:0] r_valid;

    logic                 n_clk, n_sel, n_din, n_req, n_out;
    mwe_pkg::t_phase      n_phase;
    mwe_pkg::t_bits_left  n_bits_left;
    logic [mwe_pkg::OPADDR_BITS-1:0] n_opaddr;
    mwe_pkg::t_word       n_shift;
    logic                 n_load_pend;
    logic                 n_rd_ok;

    logic                 wr_en, rd_en;
    mwe_pkg::t_ram_addr   wr_addr, rd_addr;
    mwe_pkg::t_word       wr_data, rd_data, shift_cur;
    mwe_pkg::t_bits_left  bl;
    logic [mwe_pkg::OPADDR_BITS-1:0] noa;
    mwe_pkg::t_opcode     op, cur_op;
    mwe_pkg::t_addr       addr, cur_addr;
    logic                 rise;

    mwe_ram #(
        .WIDTH (mwe_pkg::WORD_BITS),
        .DEPTH (mwe_pkg::WORD_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        shift_cur   = r_load_pend ? (r_rd_ok ? rd_data : '0) : r_shift;
        n_clk       = r_clk;
        n_sel       = r_sel;
        n_din       = r_din;
        n_req       = r_req;
        n_out       = r_out;
        n_phase     = r_phase;
        n_bits_left = r_bits_left;
        n_opaddr    = r_opaddr;
        n_shift     = shift_cur;
        n_load_pend = 1'b0;
        n_rd_ok     = r_rd_ok;
        wr_en       = 1'b0;
        wr_addr     = mwe_pkg::ram_index(i_item.load_addr);
        wr_data     = i_item.load_data;
        rd_en       = 1'b0;
        cur_op      = r_opaddr[mwe_pkg::OPADDR_BITS-1 -: mwe_pkg::OPC_BITS];
        cur_addr    = r_opaddr[mwe_pkg::ADDR_BITS-1:0];
        noa         = {r_opaddr[mwe_pkg::OPADDR_BITS-2:0], i_item.data_in_level};
        op          = noa[mwe_pkg::OPADDR_BITS-1 -: mwe_pkg::OPC_BITS];
        addr        = noa[mwe_pkg::ADDR_BITS-1:0];
        rd_addr     = mwe_pkg::ram_index(addr);
        bl          = r_bits_left - mwe_pkg::t_bits_left'(1);
        rise        = !r_clk && i_item.clock_level;

        if (i_accept) begin
            if (i_item.cmd) begin
                wr_en = mwe_pkg::addr_in_range(i_item.load_addr);
            end else begin
                n_clk = i_item.clock_level;
                n_sel = i_item.select_level;
                n_din = i_item.data_in_level;
                n_req = i_item.request_level;
                if (rise && i_item.select_level && (r_bits_left != '0)) begin
                    n_bits_left = bl;
                    case (r_phase)
                        mwe_pkg::PH_DATAOUT: begin
                            n_out   = shift_cur[mwe_pkg::WORD_BITS-1];
                            n_shift = {shift_cur[mwe_pkg::WORD_BITS-2:0], 1'b0};
                            if (bl == '0) begin
                                n_opaddr    = '0;
                                n_phase     = mwe_pkg::PH_OPADDR;
                                n_bits_left = mwe_pkg::t_bits_left'(mwe_pkg::OPADDR_BITS);
                            end
                        end
                        mwe_pkg::PH_DATAIN: begin
                            n_shift = {shift_cur[mwe_pkg::WORD_BITS-2:0],
                                       i_item.data_in_level};
                            if (bl == '0) begin
                                wr_addr     = mwe_pkg::ram_index(cur_addr);
                                wr_data     = n_shift;
                                wr_en       = (cur_op == mwe_pkg::OP_WRITE) &&
                                              mwe_pkg::addr_in_range(cur_addr);
                                n_opaddr    = '0;
                                n_phase     = mwe_pkg::PH_OPADDR;
                                n_bits_left = mwe_pkg::t_bits_left'(mwe_pkg::OPADDR_BITS);
                            end
                        end
                        mwe_pkg::PH_OPADDR: begin
                            n_opaddr = noa;
                            if (bl == '0) begin
                                case (op)
                                    mwe_pkg::OP_READ: begin
                                        n_phase     = mwe_pkg::PH_DATAOUT;
                                        n_bits_left =
                                            mwe_pkg::t_bits_left'(mwe_pkg::WORD_BITS);
                                        rd_en       = 1'b1;
                                        n_load_pend = 1'b1;
                                        n_rd_ok     = mwe_pkg::addr_in_range(addr) &&
                                                      r_valid[rd_addr];
                                    end
                                    mwe_pkg::OP_WRITE: begin
                                        n_phase     = mwe_pkg::PH_DATAIN;
                                        n_bits_left =
                                            mwe_pkg::t_bits_left'(mwe_pkg::WORD_BITS);
                                        n_shift     = '0;
                                    end
                                    mwe_pkg::OP_ERASE, mwe_pkg::OP_EWEN: begin
                                        n_opaddr    = '0;
                                        n_bits_left =
                                            mwe_pkg::t_bits_left'(mwe_pkg::OPADDR_BITS);
                                    end
                                    default: begin
                                        n_opaddr    = '0;
                                        n_bits_left =
                                            mwe_pkg::t_bits_left'(mwe_pkg::OPADDR_BITS);
                                    end
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk       <= 1'b0;
            r_sel       <= 1'b0;
            r_din       <= 1'b0;
            r_req       <= 1'b0;
            r_out       <= 1'b0;
            r_phase     <= mwe_pkg::PH_OPADDR;
            r_bits_left <= mwe_pkg::t_bits_left'(mwe_pkg::OPADDR_BITS);
            r_opaddr    <= '0;
            r_shift     <= '0;
            r_load_pend <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_clk       <= n_clk;
            r_sel       <= n_sel;
            r_din       <= n_din;
            r_req       <= n_req;
            r_out       <= n_out;
            r_phase     <= n_phase;
            r_bits_left <= n_bits_left;
            r_opaddr    <= n_opaddr;
            r_shift     <= n_shift;
            r_load_pend <= n_load_pend;
            r_rd_ok     <= n_rd_ok;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // grant mirrors the latched request
    assign o_result.data_out     = r_out;
    assign o_result.grant        = r_req;
    assign o_result.clock_echo   = r_clk;
    assign o_result.select_echo  = r_sel;
    assign o_result.data_in_echo = r_din;
    assign o_result.request_echo = r_req;

endmodule

FILE: sv/microwire_eeprom_slave.sv
// A result is offered in the cycle after its request is accepted.
// Throughput: one request per cycle; the output register is refilled in the
// cycle it is taken, so only a stalled, full output holds off input.
// A read fetches its word from the store RAM into a read data register when the opcode ends.
// Reset: synchronous, active low; store reads as zero until a word is written.
// ----------------------------------------------------------------------------
// microwire_eeprom_slave
// Bit-banged Microwire EEPROM behind a control register, with preload port.
// ----------------------------------------------------------------------------
module microwire_eeprom_slave (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_cmd,
    input  logic           i_clock_level,
    input  logic           i_select_level,
    input  logic           i_data_in_level,
    input  logic           i_request_level,
    input  mwe_pkg::t_addr i_load_addr,
    input  mwe_pkg::t_word i_load_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic           o_data_out,
    output logic           o_grant,
    output logic           o_clock_echo,
    output logic           o_select_echo,
    output logic           o_data_in_echo,
    output logic           o_request_echo
);

    logic             r_out_valid;
    logic             accept;
    mwe_pkg::t_item   item;
    mwe_pkg::t_result result;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign item.cmd           = i_cmd;
    assign item.clock_level   = i_clock_level;
    assign item.select_level  = i_select_level;
    assign item.data_in_level = i_data_in_level;
    assign item.request_level = i_request_level;
    assign item.load_addr     = i_load_addr;
    assign item.load_data     = i_load_data;

    mwe_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_data_out     = result.data_out;
    assign o_grant        = result.grant;
    assign o_clock_echo   = result.clock_echo;
    assign o_select_echo  = result.select_echo;
    assign o_data_in_echo = result.data_in_echo;
    assign o_request_echo = result.request_echo;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the Microwire EEPROM slave one request at a time. A model of the
// control register, serial machine and word store predicts the read-back
// of every accepted request. Stimulus is directed control cases, each opcode
// at least once, then random command streams with noise, random idling on both
// sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_W = $bits(mwe_pkg::t_item);

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        i_cmd           = 1'b0;
    logic        i_clock_level   = 1'b0;
    logic        i_select_level  = 1'b0;
    logic        i_data_in_level = 1'b0;
    logic        i_request_level = 1'b0;
    logic [5:0]  i_load_addr     = '0;
    logic [15:0] i_load_data     = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_data_out;
    logic        o_grant;
    logic        o_clock_echo;
    logic        o_select_echo;
    logic        o_data_in_echo;
    logic        o_request_echo;

    microwire_eeprom_slave i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_clock_level   (i_clock_level),
        .i_select_level  (i_select_level),
        .i_data_in_level (i_data_in_level),
        .i_request_level (i_request_level),
        .i_load_addr     (i_load_addr),
        .i_load_data     (i_load_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_out      (o_data_out),
        .o_grant         (o_grant),
        .o_clock_echo    (o_clock_echo),
        .o_select_echo   (o_select_echo),
        .o_data_in_echo  (o_data_in_echo),
        .o_request_echo  (o_request_echo)
    );

    always #1 i_clk = ~i_clk;

    // model state
    logic                            lat_clock   = 1'b0;
    logic                            lat_select  = 1'b0;
    logic                            lat_din     = 1'b0;
    logic                            lat_request = 1'b0;
    logic                            out_bit     = 1'b0;
    logic                            grant_bit   = 1'b0;
    mwe_pkg::t_phase                 cur_phase   = mwe_pkg::PH_OPADDR;
    int                              bits_left   = mwe_pkg::OPADDR_BITS;
    logic [mwe_pkg::OPADDR_BITS-1:0] op_addr     = '0;
    mwe_pkg::t_word                  shift_word  = '0;
    mwe_pkg::t_word                  mem_img [mwe_pkg::WORD_COUNT];

    mwe_pkg::t_result readback_q [$];
    mwe_pkg::t_result got_result;
    mwe_pkg::t_result want_result;
    int      n_requests   = 0;
    int      n_mismatch   = 0;
    int      snd_idle_pct = 0;
    int      rcv_idle_pct = 0;
    int      hold_reqs    = 0;
    int      hold_seen    = 0;
    int      stall_hold   = 0;

    function automatic void restart_command();
        op_addr   = '0;
        cur_phase = mwe_pkg::PH_OPADDR;
        bits_left = mwe_pkg::OPADDR_BITS;
    endfunction

    function automatic mwe_pkg::t_result eeprom_step(input mwe_pkg::t_item it);
        mwe_pkg::t_result r;
        logic             rise;
        mwe_pkg::t_opcode op;
        mwe_pkg::t_addr   adr;
        if (it.cmd) begin
            if (int'(it.load_addr) < mwe_pkg::WORD_COUNT)
                mem_img[it.load_addr] = it.load_data;
        end else begin
            rise        = !lat_clock && it.clock_level;
            lat_clock   = it.clock_level;
            lat_select  = it.select_level;
            lat_din     = it.data_in_level;
            lat_request = it.request_level;
            grant_bit   = lat_request;
            if (rise && lat_select && bits_left != 0) begin
                bits_left--;
                case (cur_phase)
                    mwe_pkg::PH_DATAOUT: begin
                        out_bit    = shift_word[mwe_pkg::WORD_BITS-1];
                        shift_word = shift_word << 1;
                        if (bits_left == 0)
                            restart_command();
                    end
                    mwe_pkg::PH_DATAIN: begin
                        shift_word = {shift_word[mwe_pkg::WORD_BITS-2:0], lat_din};
                        if (bits_left == 0) begin
                            op  = op_addr[mwe_pkg::OPADDR_BITS-1 -: mwe_pkg::OPC_BITS];
                            adr = op_addr[mwe_pkg::ADDR_BITS-1:0];
                            if (op == mwe_pkg::OP_WRITE && int'(adr) < mwe_pkg::WORD_COUNT)
                                mem_img[adr] = shift_word;
                            restart_command();
                        end
                    end
                    mwe_pkg::PH_OPADDR: begin
                        op_addr = {op_addr[mwe_pkg::OPADDR_BITS-2:0], lat_din};
                        if (bits_left == 0) begin
                            op  = op_addr[mwe_pkg::OPADDR_BITS-1 -: mwe_pkg::OPC_BITS];
                            adr = op_addr[mwe_pkg::ADDR_BITS-1:0];
                            if (op == mwe_pkg::OP_READ) begin
                                cur_phase  = mwe_pkg::PH_DATAOUT;
                                bits_left  = mwe_pkg::WORD_BITS;
                                shift_word = (int'(adr) < mwe_pkg::WORD_COUNT) ?
                                             mem_img[adr] : '0;
                            end else if (op == mwe_pkg::OP_WRITE) begin
                                cur_phase  = mwe_pkg::PH_DATAIN;
                                bits_left  = mwe_pkg::WORD_BITS;
                                shift_word = '0;
                            end else begin
                                restart_command();
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        r.data_out     = out_bit;
        r.grant        = grant_bit;
        r.clock_echo   = lat_clock;
        r.select_echo  = lat_select;
        r.data_in_echo = lat_din;
        r.request_echo = lat_request;
        return r;
    endfunction

    // send one request; the model is stepped at acceptance
    task automatic send_request(input mwe_pkg::t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_clock_level   <= it.clock_level;
        i_select_level  <= it.select_level;
        i_data_in_level <= it.data_in_level;
        i_request_level <= it.request_level;
        i_load_addr     <= it.load_addr;
        i_load_data     <= it.load_data;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        readback_q.push_back(eeprom_step(it));
        n_requests++;
    endtask

    function automatic mwe_pkg::t_item random_item();
        mwe_pkg::t_item it;
        it     = mwe_pkg::t_item'(ITEM_W'($urandom));
        it.cmd = ($urandom_range(3) == 0);
        return it;
    endfunction

    task automatic ctrl_write(input logic clk, input logic sel, input logic din,
                              input logic req);
        mwe_pkg::t_item it;
        it               = random_item();
        it.cmd           = 1'b0;
        it.clock_level   = clk;
        it.select_level  = sel;
        it.data_in_level = din;
        it.request_level = req;
        send_request(it);
    endtask

    task automatic preload(input mwe_pkg::t_addr adr, input mwe_pkg::t_word dat);
        mwe_pkg::t_item it;
        it           = random_item();
        it.cmd       = 1'b1;
        it.load_addr = adr;
        it.load_data = dat;
        send_request(it);
    endtask

    task automatic shift_bit(input logic din, input bit noisy);
        if (noisy && $urandom_range(99) < 4)
            send_request(random_item());
        ctrl_write(1'b0, 1'b1, din, 1'($urandom_range(1)));
        ctrl_write(1'b1, 1'b1, din, 1'($urandom_range(1)));
    endtask

    task automatic serial_command(input mwe_pkg::t_opcode op, input mwe_pkg::t_addr adr,
                                  input mwe_pkg::t_word dat, input bit noisy);
        // clock filler bits until the machine waits for a fresh opcode
        while (!(cur_phase == mwe_pkg::PH_OPADDR && bits_left == mwe_pkg::OPADDR_BITS))
            shift_bit(1'($urandom_range(1)), 1'b0);
        for (int i = mwe_pkg::OPC_BITS - 1; i >= 0; i--)
            shift_bit(op[i], noisy);
        for (int i = mwe_pkg::ADDR_BITS - 1; i >= 0; i--)
            shift_bit(adr[i], noisy);
        if (op == mwe_pkg::OP_READ || op == mwe_pkg::OP_WRITE) begin
            for (int i = mwe_pkg::WORD_BITS - 1; i >= 0; i--)
                shift_bit((op == mwe_pkg::OP_WRITE) ? dat[i] : 1'($urandom_range(1)),
                          noisy);
        end
        if ($urandom_range(1))
            ctrl_write(1'b0, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic run_traffic(input int n);
        int               stop_at;
        int               pick;
        mwe_pkg::t_opcode op;
        mwe_pkg::t_addr   adr;
        stop_at = n_requests + n;
        while (n_requests < stop_at) begin
            if ($urandom_range(99) < 85) begin
                pick = $urandom_range(9);
                if (pick < 4)
                    op = mwe_pkg::OP_READ;
                else if (pick < 8)
                    op = mwe_pkg::OP_WRITE;
                else
                    op = mwe_pkg::t_opcode'($urandom);
                adr = $urandom_range(1) ? mwe_pkg::t_addr'($urandom_range(7)) :
                                          mwe_pkg::t_addr'($urandom);
                serial_command(op, adr, mwe_pkg::t_word'($urandom), 1'b1);
            end else begin
                repeat ($urandom_range(1, 8))
                    send_request(random_item());
            end
        end
    endtask

    task automatic test_control_bits();
        preload(mwe_pkg::t_addr'(mwe_pkg::WORD_COUNT - 1), 16'hFFFF);
        preload('0, 16'h8001);
        ctrl_write(1'b0, 1'b0, 1'b0, 1'b0);
        // rising clock with select low: no shift
        ctrl_write(1'b1, 1'b0, 1'b1, 1'b1);
        ctrl_write(1'b0, 1'b1, 1'b0, 1'b0);
        ctrl_write(1'b1, 1'b1, 1'b1, 1'b1);
        // clock held high: no shift
        ctrl_write(1'b1, 1'b1, 1'b0, 1'b1);
        ctrl_write(1'b0, 1'b1, 1'b1, 1'b0);
        ctrl_write(1'b1, 1'b1, 1'b0, 1'b0);
        // select low keeps the command position
        ctrl_write(1'b0, 1'b0, 1'b0, 1'b1);
        ctrl_write(1'b1, 1'b0, 1'b1, 1'b0);
        ctrl_write(1'b0, 1'b1, 1'b1, 1'b1);
        ctrl_write(1'b1, 1'b1, 1'b1, 1'b1);
        // preload leaves control bits alone
        preload(mwe_pkg::t_addr'($urandom), mwe_pkg::t_word'($urandom));
    endtask

    task automatic test_each_opcode();
        serial_command(mwe_pkg::OP_READ, mwe_pkg::t_addr'(mwe_pkg::WORD_COUNT - 1), '0, 1'b0);
        serial_command(mwe_pkg::OP_READ, '0, '0, 1'b0);
        serial_command(mwe_pkg::OP_WRITE, '0, mwe_pkg::t_word'($urandom), 1'b0);
        serial_command(mwe_pkg::OP_READ, '0, '0, 1'b0);
        serial_command(mwe_pkg::OP_WRITE, mwe_pkg::t_addr'(mwe_pkg::WORD_COUNT - 1), '0, 1'b0);
        serial_command(mwe_pkg::OP_EWEN, mwe_pkg::t_addr'($urandom), '0, 1'b0);
        serial_command(mwe_pkg::OP_ERASE, '0, '0, 1'b0);
        serial_command(mwe_pkg::OP_READ, '0, '0, 1'b0);
        serial_command(mwe_pkg::OP_READ, mwe_pkg::t_addr'(mwe_pkg::WORD_COUNT - 1), '0, 1'b0);
        for (int v = 0; v < 4; v++)
            serial_command(mwe_pkg::t_opcode'(v), mwe_pkg::t_addr'($urandom), '0, 1'b0);
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        run_traffic(n);
    endtask

    task automatic test_output_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_reqs++;
        run_traffic(100);
    endtask

    // receiver: random idling, or a long hold-off counted here
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen  = hold_reqs;
            stall_hold = 64;
        end
        if (stall_hold != 0) begin
            i_out_stall <= 1'b1;
            stall_hold--;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    function automatic void compare_bit(input string field, input logic want,
                                        input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
            n_mismatch++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_result = {o_data_out, o_grant, o_clock_echo, o_select_echo,
                          o_data_in_echo, o_request_echo};
            if (readback_q.size() == 0) begin
                $display("%0t: result with no request pending, expected none, actual %p",
                         $time, got_result);
                n_mismatch++;
            end else begin
                want_result = readback_q.pop_front();
                compare_bit("data_out", want_result.data_out, got_result.data_out);
                compare_bit("grant", want_result.grant, got_result.grant);
                compare_bit("clock_echo", want_result.clock_echo, got_result.clock_echo);
                compare_bit("select_echo", want_result.select_echo, got_result.select_echo);
                compare_bit("data_in_echo", want_result.data_in_echo,
                            got_result.data_in_echo);
                compare_bit("request_echo", want_result.request_echo,
                            got_result.request_echo);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int drain;
        foreach (mem_img[i])
            mem_img[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle_pct = 11;
        rcv_idle_pct = 70;
        test_control_bits();
        test_each_opcode();
        test_random_traffic(11, 70, 450);
        test_random_traffic(70, 11, 550);
        test_output_backpressure();
        test_random_traffic(0, 0, 500);
        i_in_valid <= 1'b0;
        drain = 0;
        while (readback_q.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (readback_q.size() != 0) begin
            $display("%0t: %0d results expected, actual none", $time, readback_q.size());
            n_mismatch += readback_q.size();
        end
        if (n_mismatch == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/mwe_pkg.sv
sv/mwe_ram.sv
sv/mwe_serial.sv
sv/microwire_eeprom_slave.sv
tb/testbench.sv
